>>> sv/sff_pkg.sv
// shared constants, types and constant tables for the stereo flanger
package sff_pkg;

  localparam int DELAY_DEPTH       = 2048;
  localparam int DLY_AW            = $clog2(DELAY_DEPTH);
  localparam int MIN_DELAY_SAMPLES = 12;
  localparam int MAX_DELAY_SAMPLES = 576;
  localparam int SAMPLE_BITS       = 24;
  localparam int SINE_TABLE_SIZE   = 1024;
  localparam int SINE_AW           = $clog2(SINE_TABLE_SIZE);
  localparam int TANH_POINTS       = 256;
  localparam int TANH_FRAC_BITS    = SAMPLE_BITS - 8;
  localparam int LFO_BITS          = 17;

  // delay clamp in samples with 8 fractional bits
  localparam int D_LO_S  = (MIN_DELAY_SAMPLES < 1) ? 1 : MIN_DELAY_SAMPLES;
  localparam int D_HI_S0 = (MAX_DELAY_SAMPLES > DELAY_DEPTH - 2) ?
                           (DELAY_DEPTH - 2) : MAX_DELAY_SAMPLES;
  localparam int D_HI_S  = (D_HI_S0 < D_LO_S) ? D_LO_S : D_HI_S0;
  localparam int D_LO    = D_LO_S * 256;
  localparam int D_HI    = D_HI_S * 256;

  localparam int SMAX = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SMIN = -SMAX - 1;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [63:0] Q30          = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

  typedef logic [LFO_BITS-1:0]    lfo_rom_t  [SINE_TABLE_SIZE];
  typedef logic [SAMPLE_BITS-1:0] tanh_rom_t [TANH_POINTS+1];

  // register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_ENABLED     = 3'd0,
    REG_BASE_DELAY  = 3'd1,
    REG_SWEEP_DEPTH = 3'd2,
    REG_PHASE_STEP  = 3'd3,
    REG_FEEDBACK    = 3'd4,
    REG_WET_MIX     = 3'd5,
    REG_OUTPUT_GAIN = 3'd6
  } reg_idx_t;

  // sequencer states, one channel runs LFO through OUT
  typedef enum logic [3:0] {
    ST_IDLE, ST_LFO, ST_SWEEP, ST_DLY, ST_RD1, ST_DIFF, ST_INTERP,
    ST_FB, ST_TANH, ST_WR, ST_MIX, ST_OUT, ST_DONE
  } state_t;

  // unsigned quotient by shift and subtract, table building only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // taylor divisors of the sine series
  function automatic logic [63:0] sine_div(input int k);
    logic [63:0] r;
    unique case (k)
      0:       r = 64'd156;
      1:       r = 64'd110;
      2:       r = 64'd72;
      3:       r = 64'd42;
      4:       r = 64'd20;
      default: r = 64'd6;
    endcase
    return r;
  endfunction

  // sin of a q30 angle in [0, pi/2]
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2, t;
    x2 = (x * x) >> 30;
    t  = Q30;
    for (int k = 0; k < 6; k++) begin
      t = Q30 - udiv64((x2 * t) >> 30, sine_div(k));
    end
    t = (x * t) >> 30;
    return (t > Q30) ? Q30 : t;
  endfunction

  // unipolar lfo table, q1.16
  function automatic lfo_rom_t build_lfo_rom();
    lfo_rom_t    tab;
    logic [31:0] p;
    logic [63:0] r, s, u;
    for (int i = 0; i < SINE_TABLE_SIZE; i++) begin
      p = 32'(i) << (32 - SINE_AW);
      r = 64'(p[29:0]);
      if (p[30]) r = Q30 - r;
      s = sine_q30((r * HALF_PI_Q30) >> 30);
      u = p[31] ? (Q30 - s) : (Q30 + s);
      tab[i] = LFO_BITS'((u + 64'd16384) >> 15);
    end
    return tab;
  endfunction

  // tanh(k/128) table, q1.23
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t   tab;
    logic [63:0] c, term, e, num, den;
    c    = Q30;
    term = Q30;
    for (int i = 1; i <= 6; i++) begin
      term = udiv64(term >> 6, 64'(i));
      if ((i & 1) == 1) c = c - term;
      else              c = c + term;
    end
    e = Q30;
    for (int i = 0; i <= TANH_POINTS; i++) begin
      num = (Q30 - e) << (SAMPLE_BITS - 1);
      den = Q30 + e;
      tab[i] = SAMPLE_BITS'(udiv64(num + (den >> 1), den));
      e = (e * c) >> 30;
    end
    return tab;
  endfunction

endpackage

>>> sv/sff_in_if.sv
// input stream of stereo words
interface sff_in_if import sff_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

>>> sv/sff_out_if.sv
// output stream of stereo words
interface sff_out_if import sff_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

>>> sv/stereo_flanger_feedback_unit.sv
// stereo flanger with feedback, one shared multiplier under a sequencer
//
//   channel     dir   handshake          payload
//   sample_in   in    valid / ready      left_in, right_in (s24)
//   sample_out  out   valid / ready      left_out, right_out (s24)
//   apb         in    psel/penable/...   7 registers at 4*i
//
// an enabled word: accept, LFO through OUT per channel via the shared 27x18
// multiplier and the delay memory (a read and a write port), hand off in DONE
// a bypassed word skips to DONE; a stalled output holds the sequencer in DONE
// reset is synchronous; the delay memory is not swept, a fill count masks
// entries not yet written since reset or bypass, so there is no clearing pass
module stereo_flanger_feedback_unit import sff_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sff_in_if.sink      sample_in,
  sff_out_if.source   sample_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam lfo_rom_t  LFO_ROM  = build_lfo_rom();
  localparam tanh_rom_t TANH_ROM = build_tanh_rom();
  localparam int        MA = 27;
  localparam int        MB = 18;
  localparam int        MP = MA + MB;
  localparam int        RPW = DLY_AW + 8;

  // configuration registers
  logic               enabled;
  logic [17:0]        base_delay;
  logic [16:0]        sweep_depth;
  logic [30:0]        phase_step;
  logic signed [15:0] feedback_gain;
  logic [16:0]        wet_mix;
  logic [15:0]        output_gain;

  // sequencer and datapath state
  state_t                        state, state_next;
  logic                          ch;
  logic [31:0]                   lfo_phase;
  logic [DLY_AW-1:0]             write_position;
  logic [DLY_AW:0]               fill;
  logic [LFO_BITS-1:0]           lfo_q;
  logic signed [MP-1:0]          p;
  logic [DLY_AW-1:0]             i1;
  logic [7:0]                    frac;
  logic                          v0, v1;
  logic signed [SAMPLE_BITS-1:0] rd_q, s0, delayed, dry_l, dry_r;
  logic [SAMPLE_BITS-1:0]        t0, t1;
  logic [TANH_FRAC_BITS-1:0]     tfrac;
  logic                          neg;
  logic signed [SAMPLE_BITS-1:0] lres, rres;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;

  logic [SAMPLE_BITS-1:0]        dly_mem [2*DELAY_DEPTH];

  // combinational datapath
  logic                          in_acc, out_free;
  logic signed [MA-1:0]          mul_a;
  logic signed [MB-1:0]          mul_b;
  logic                          mem_we;
  logic [DLY_AW:0]               rd_addr;
  logic signed [SAMPLE_BITS-1:0] dry, s1, delayed_c, mixed, y, wdata;
  logic [31:0]                   phase_ch;
  logic [18:0]                   d_sum, d_cl;
  logic [RPW-1:0]                rp;
  logic [DLY_AW-1:0]             i0_c;
  logic signed [SAMPLE_BITS+1:0] x, ax;
  logic [SAMPLE_BITS-1:0]        a_sat;
  logic [8:0]                    tidx1;
  logic signed [MP-1:0]          sh;
  logic signed [SAMPLE_BITS-1:0] sat_v;
  logic [16:0]                   wm;
  reg_idx_t                      widx;

  assign in_acc   = sample_in.valid && sample_in.ready;
  assign out_free = !out_valid || sample_out.ready;
  assign pready   = 1'b1;
  assign widx     = reg_idx_t'(paddr[4:2]);

  // apb writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled       <= 1'b1;
      base_delay    <= 18'd27034;
      sweep_depth   <= 17'd58982;
      phase_step    <= 31'd31317;
      feedback_gain <= 16'sd15729;
      wet_mix       <= 17'd38011;
      output_gain   <= 16'd16384;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_ENABLED:     enabled       <= pwdata[0];
        REG_BASE_DELAY:  base_delay    <= pwdata[17:0];
        REG_SWEEP_DEPTH: sweep_depth   <= pwdata[16:0];
        REG_PHASE_STEP:  phase_step    <= pwdata[30:0];
        REG_FEEDBACK:    feedback_gain <= $signed(pwdata[15:0]);
        REG_WET_MIX:     wet_mix       <= pwdata[16:0];
        REG_OUTPUT_GAIN: output_gain   <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  // apb reads
  always_comb begin
    unique case (widx)
      REG_ENABLED:     prdata = {31'd0, enabled};
      REG_BASE_DELAY:  prdata = {14'd0, base_delay};
      REG_SWEEP_DEPTH: prdata = {15'd0, sweep_depth};
      REG_PHASE_STEP:  prdata = {1'b0, phase_step};
      REG_FEEDBACK:    prdata = {{16{feedback_gain[15]}}, feedback_gain};
      REG_WET_MIX:     prdata = {15'd0, wet_mix};
      REG_OUTPUT_GAIN: prdata = {16'd0, output_gain};
      default:         prdata = 32'd0;
    endcase
  end

  // per-step arithmetic around the shared multiplier
  always_comb begin
    dry       = ch ? dry_r : dry_l;
    phase_ch  = ch ? (lfo_phase + QUARTER_TURN) : lfo_phase;
    d_sum     = {1'b0, base_delay} + {1'b0, p[33:16]};
    if (d_sum < 19'(D_LO))      d_cl = 19'(D_LO);
    else if (d_sum > 19'(D_HI)) d_cl = 19'(D_HI);
    else                        d_cl = d_sum;
    rp        = {write_position, 8'h00} - RPW'(d_cl);
    i0_c      = rp[RPW-1:8];
    s1        = v1 ? rd_q : '0;
    delayed_c = s0 + SAMPLE_BITS'(p >>> 8);
    x         = (SAMPLE_BITS+2)'(dry) + (SAMPLE_BITS+2)'(p >>> 15);
    ax        = x[SAMPLE_BITS+1] ? -x : x;
    a_sat     = (ax > (SAMPLE_BITS+2)'(SMAX * 2 + 1)) ? '1 : ax[SAMPLE_BITS-1:0];
    tidx1     = {1'b0, a_sat[SAMPLE_BITS-1:TANH_FRAC_BITS]} + 9'd1;
    y         = $signed(t0 + SAMPLE_BITS'(p >>> TANH_FRAC_BITS));
    wdata     = neg ? -y : y;
    mixed     = dry + SAMPLE_BITS'(p >>> 16);
    wm        = wet_mix[16] ? 17'h10000 : wet_mix;
    sh        = p >>> 14;
    if (sh > MP'(SMAX))      sat_v = SAMPLE_BITS'(SMAX);
    else if (sh < MP'(SMIN)) sat_v = SAMPLE_BITS'(SMIN);
    else                     sat_v = SAMPLE_BITS'(sh);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc) state_next = enabled ? ST_LFO : ST_DONE;
      ST_LFO:    state_next = ST_SWEEP;
      ST_SWEEP:  state_next = ST_DLY;
      ST_DLY:    state_next = ST_RD1;
      ST_RD1:    state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_INTERP;
      ST_INTERP: state_next = ST_FB;
      ST_FB:     state_next = ST_TANH;
      ST_TANH:   state_next = ST_WR;
      ST_WR:     state_next = ST_MIX;
      ST_MIX:    state_next = ST_OUT;
      ST_OUT:    state_next = ch ? ST_DONE : ST_LFO;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, multiplier operands, memory control
  always_comb begin
    sample_in.ready = (state == ST_IDLE);
    mul_a   = '0;
    mul_b   = '0;
    mem_we  = (state == ST_WR);
    rd_addr = (state == ST_DLY) ? {ch, i0_c} : {ch, i1};
    unique case (state)
      ST_SWEEP: begin
        mul_a = $signed(MA'(sweep_depth));
        mul_b = $signed(MB'(lfo_q));
      end
      ST_DIFF: begin
        mul_a = MA'((SAMPLE_BITS+1)'(s1) - (SAMPLE_BITS+1)'(s0));
        mul_b = $signed(MB'(frac));
      end
      ST_INTERP: begin
        mul_a = MA'(delayed_c);
        mul_b = MB'(feedback_gain);
      end
      ST_TANH: begin
        mul_a = $signed(MA'(t1 - t0));
        mul_b = $signed(MB'(tfrac));
      end
      ST_WR: begin
        mul_a = MA'((SAMPLE_BITS+1)'(delayed) - (SAMPLE_BITS+1)'(dry));
        mul_b = $signed(MB'(wm));
      end
      ST_MIX: begin
        mul_a = MA'(mixed);
        mul_b = $signed(MB'(output_gain));
      end
      default: ;
    endcase
  end

  // delay memory, both channels, registered read
  always_ff @(posedge clk) begin
    if (mem_we) dly_mem[{ch, write_position}] <= wdata;
    rd_q <= $signed(dly_mem[rd_addr]);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
    unique case (state)
      ST_IDLE: begin
        dry_l <= sample_in.left_in;
        dry_r <= sample_in.right_in;
        lres  <= sample_in.left_in;
        rres  <= sample_in.right_in;
      end
      ST_LFO:  lfo_q <= LFO_ROM[phase_ch[31:32-SINE_AW]];
      ST_DLY: begin
        i1   <= i0_c + DLY_AW'(1);
        frac <= rp[7:0];
        v0   <= {1'b0, i0_c} < fill;
        v1   <= {1'b0, DLY_AW'(i0_c + DLY_AW'(1))} < fill;
      end
      ST_RD1:    s0 <= v0 ? rd_q : '0;
      ST_INTERP: delayed <= delayed_c;
      ST_FB: begin
        t0    <= TANH_ROM[a_sat[SAMPLE_BITS-1:TANH_FRAC_BITS]];
        t1    <= TANH_ROM[tidx1];
        tfrac <= a_sat[TANH_FRAC_BITS-1:0];
        neg   <= x[SAMPLE_BITS+1];
      end
      ST_OUT: begin
        if (ch) rres <= sat_v;
        else    lres <= sat_v;
      end
      default: ;
    endcase
  end

  // control state: channel, lfo phase, write position, fill, output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      ch             <= 1'b0;
      lfo_phase      <= '0;
      write_position <= '0;
      fill           <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_acc && !enabled) begin
        write_position <= '0;
        fill           <= '0;
      end
      if (state == ST_OUT) begin
        ch <= !ch;
        if (ch) begin
          write_position <= write_position + DLY_AW'(1);
          lfo_phase      <= lfo_phase + {1'b0, phase_step};
          if (fill != (DLY_AW+1)'(DELAY_DEPTH)) fill <= fill + (DLY_AW+1)'(1);
        end
      end
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (sample_out.ready)        out_valid <= 1'b0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      left_q  <= lres;
      right_q <= rres;
    end
  end

  assign sample_out.valid     = out_valid;
  assign sample_out.left_out  = left_q;
  assign sample_out.right_out = right_q;

endmodule

>>> sv/sff_checker.sv
// port-level checks on the flanger top level, bound in below
module sff_checker import sff_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] left_out,
  input logic [SAMPLE_BITS-1:0] right_out,
  input logic                   pready
);

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accept");

  // a new output word only appears as the sequencer finishes
  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("output word without work in flight");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("stalled output word changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // config port never waits
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind stereo_flanger_feedback_unit sff_checker u_sff_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample_in.valid),
  .in_ready  (sample_in.ready),
  .out_valid (sample_out.valid),
  .out_ready (sample_out.ready),
  .left_out  (sample_out.left_out),
  .right_out (sample_out.right_out),
  .pready    (pready)
);
